// ----- hdl/hsv_rainbow_to_rgbw_pixel_core_macros.svh -----
// Assertion macros shared by the pixel core.
`ifndef HSV_RAINBOW_TO_RGBW_PIXEL_CORE_MACROS_SVH
`define HSV_RAINBOW_TO_RGBW_PIXEL_CORE_MACROS_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define HSVRGBW_ASSERT_NOW(label, clk, rst, cond, consq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (consq)) \
      else $error(msg);

// Condition in a cycle implies a consequence in the next cycle.
`define HSVRGBW_ASSERT_NEXT(label, clk, rst, cond, consq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (consq)) \
      else $error(msg);

`endif

// ----- hdl/hsvrgbw_pkg.sv -----
package hsvrgbw_pkg;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_CORR_RED      = 3'd0,
      CSR_CORR_GREEN    = 3'd1,
      CSR_CORR_BLUE     = 3'd2,
      CSR_SAT_GAIN      = 3'd3,
      CSR_BRIGHTNESS    = 3'd4,
      CSR_STRIP_WHITE   = 3'd5,
      CSR_CHANNEL_ORDER = 3'd6
   } csr_index_type;

   // Rainbow segments selected by the top three hue bits.
   typedef enum logic [2:0] {
      SEG_RED    = 3'd0,
      SEG_ORANGE = 3'd1,
      SEG_YELLOW = 3'd2,
      SEG_GREEN  = 3'd3,
      SEG_AQUA   = 3'd4,
      SEG_BLUE   = 3'd5,
      SEG_PURPLE = 3'd6,
      SEG_PINK   = 3'd7
   } seg_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [7:0] LEVEL_MAX   = 8'd255;
   localparam logic [7:0] LEVEL_HIGH  = 8'd171;
   localparam logic [7:0] LEVEL_LOW   = 8'd85;
   localparam logic [7:0] LEVEL_MID   = 8'd170;
   localparam logic [7:0] THIRD_RECIP = 8'd171;
   localparam logic [8:0] WHITE_SHIFT = 9'd8;
   localparam logic [8:0] WORD_BITS   = 9'd32;

   localparam logic [23:0] CHANNEL_ORDER_RESET = 24'h081000;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] w;
   } px_type;

   // First stage: gained saturation, squared value, rainbow levels.
   typedef struct packed {
      logic [7:0] sat;
      logic [7:0] vsq;
      rgb_type    rb;
   } s1_type;

   // Second stage: scaled value, desaturation term, saturation products.
   typedef struct packed {
      logic       sat_zero;
      logic       sat_full;
      logic [7:0] val;
      logic [7:0] desat;
      rgb_type    rb;
      rgb_type    rs;
   } s2_type;

   // Eight-bit scaling: (a * b) >> 8.
   function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] p;
      p = {8'd0, a} * {8'd0, b};
      return p[15:8];
   endfunction

   // Offset times eight, divided by three through a reciprocal multiply.
   function automatic logic [7:0] third_of(input logic [4:0] off);
      logic [15:0] p;
      p = {8'd0, off, 3'b000} * {8'd0, THIRD_RECIP};
      return {1'b0, p[15:9]};
   endfunction

   // Eight-segment rainbow; all sums wrap at eight bits.
   function automatic rgb_type rainbow(input logic [7:0] hue);
      logic [7:0] t;
      logic [7:0] t2;
      rgb_type    c;
      t  = third_of(hue[4:0]);
      t2 = {t[6:0], 1'b0};
      case (seg_type'(hue[7:5]))
         SEG_RED: begin
            c.r = LEVEL_MAX - t;   c.g = t;               c.b = 8'd0;
         end
         SEG_ORANGE: begin
            c.r = LEVEL_HIGH;      c.g = LEVEL_LOW + t;   c.b = 8'd0;
         end
         SEG_YELLOW: begin
            c.r = LEVEL_HIGH - t2; c.g = LEVEL_MID + t;   c.b = 8'd0;
         end
         SEG_GREEN: begin
            c.r = 8'd0;            c.g = LEVEL_MAX - t;   c.b = t;
         end
         SEG_AQUA: begin
            c.r = 8'd0;            c.g = LEVEL_HIGH - t2; c.b = LEVEL_LOW + t2;
         end
         SEG_BLUE: begin
            c.r = t;               c.g = 8'd0;            c.b = LEVEL_MAX - t;
         end
         SEG_PURPLE: begin
            c.r = LEVEL_LOW + t;   c.g = 8'd0;            c.b = LEVEL_HIGH - t;
         end
         default: begin
            c.r = LEVEL_MID + t;   c.g = 8'd0;            c.b = LEVEL_LOW - t;
         end
      endcase
      return c;
   endfunction

   // Shift a level into the word; a shift of 32 or more drops it.
   function automatic logic [31:0] place(input logic [7:0] level, input logic [7:0] shift,
                                         input logic white);
      logic [8:0] amount;
      amount = {1'b0, shift} + (white ? WHITE_SHIFT : 9'd0);
      if (amount >= WORD_BITS) begin
         return 32'd0;
      end
      return {24'd0, level} << amount[4:0];
   endfunction

endpackage

// ----- hdl/hsv_rainbow_to_rgbw_pixel_core.sv -----
// HSV rainbow to packed RGB/RGBW pixel core.
// Input channel req_: one beat carries hue, saturation and value of a pixel.
// Result channel rsp_: one beat carries the packed LED word and the red,
// green, blue and white levels of that pixel. Both channels use valid and
// stall; a beat moves at a clock edge with valid high and stall low.
// Configuration port csr_: a write at an edge with csr_wr_en high sets the
// register named by csr_index; indexes past the list are ignored. Write it
// only while no pixel is in flight.
// A pixel passes through five register stages (scaling, saturation products,
// desaturation and value, colour correction, packing), each holding one pixel;
// rsp_valid rises when it reaches the last. One pixel per cycle while
// rsp_stall stays low.
// When rsp_stall is high the output beat holds, empty stages behind it still
// fill, and req_stall rises once every stage is occupied.
// Reset (synchronous, active high) empties the pipeline and restores the
// configuration defaults: unity gains and corrections, RGB strip, red at
// shift 8, green at 16, blue at 0.
`include "hsv_rainbow_to_rgbw_pixel_core_macros.svh"

module hsv_rainbow_to_rgbw_pixel_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_hue,
   input  logic [7:0]                           req_sat_in,
   input  logic [7:0]                           req_value_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_pixel_word,
   output logic [7:0]                           rsp_red_out,
   output logic [7:0]                           rsp_green_out,
   output logic [7:0]                           rsp_blue_out,
   output logic [7:0]                           rsp_white_out,
   input  logic                                 csr_wr_en,
   input  logic [hsvrgbw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [hsvrgbw_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [7:0]  corr_red_ff;
   logic [7:0]  corr_green_ff;
   logic [7:0]  corr_blue_ff;
   logic [7:0]  sat_gain_ff;
   logic [7:0]  brightness_ff;
   logic        strip_white_ff;
   logic [23:0] channel_order_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic en1, en2, en3, en4, en5;

   hsvrgbw_pkg::s1_type s1_ff, s1_in;
   hsvrgbw_pkg::s2_type s2_ff, s2_in;
   hsvrgbw_pkg::px_type s3_ff, s3_in;
   hsvrgbw_pkg::px_type s4_ff, s4_in;
   hsvrgbw_pkg::px_type s5_ff;
   logic [31:0]         word_ff, word_in;

   logic [7:0]          vadj;
   logic [7:0]          inv;
   hsvrgbw_pkg::px_type mix;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         corr_red_ff      <= hsvrgbw_pkg::LEVEL_MAX;
         corr_green_ff    <= hsvrgbw_pkg::LEVEL_MAX;
         corr_blue_ff     <= hsvrgbw_pkg::LEVEL_MAX;
         sat_gain_ff      <= hsvrgbw_pkg::LEVEL_MAX;
         brightness_ff    <= hsvrgbw_pkg::LEVEL_MAX;
         strip_white_ff   <= 1'b0;
         channel_order_ff <= hsvrgbw_pkg::CHANNEL_ORDER_RESET;
      end else if (csr_wr_en) begin
         case (hsvrgbw_pkg::csr_index_type'(csr_index))
            hsvrgbw_pkg::CSR_CORR_RED:      corr_red_ff      <= csr_wdata[7:0];
            hsvrgbw_pkg::CSR_CORR_GREEN:    corr_green_ff    <= csr_wdata[7:0];
            hsvrgbw_pkg::CSR_CORR_BLUE:     corr_blue_ff     <= csr_wdata[7:0];
            hsvrgbw_pkg::CSR_SAT_GAIN:      sat_gain_ff      <= csr_wdata[7:0];
            hsvrgbw_pkg::CSR_BRIGHTNESS:    brightness_ff    <= csr_wdata[7:0];
            hsvrgbw_pkg::CSR_STRIP_WHITE:   strip_white_ff   <= csr_wdata[0];
            hsvrgbw_pkg::CSR_CHANNEL_ORDER: channel_order_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Each stage advances when it is empty or the stage after it advances.
   assign en5       = !v5_ff || !rsp_stall;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
      end
   end

   // Stage one: saturation gain, value squared, rainbow levels.
   always_comb begin
      s1_in.sat = hsvrgbw_pkg::mul8(req_sat_in, sat_gain_ff);
      s1_in.vsq = hsvrgbw_pkg::mul8(req_value_in, req_value_in);
      s1_in.rb  = hsvrgbw_pkg::rainbow(req_hue);
   end

   // Stage two: brightness, desaturation term, saturation products.
   always_comb begin
      vadj = s1_ff.vsq;
      if (s1_ff.vsq != 8'd0 && s1_ff.vsq != hsvrgbw_pkg::LEVEL_MAX) begin
         vadj = s1_ff.vsq + 8'd1;
      end
      inv            = hsvrgbw_pkg::LEVEL_MAX - s1_ff.sat;
      s2_in.sat_zero = (s1_ff.sat == 8'd0);
      s2_in.sat_full = (s1_ff.sat == hsvrgbw_pkg::LEVEL_MAX);
      s2_in.val      = hsvrgbw_pkg::mul8(vadj, brightness_ff);
      s2_in.desat    = hsvrgbw_pkg::mul8(inv, inv);
      s2_in.rb       = s1_ff.rb;
      s2_in.rs.r     = hsvrgbw_pkg::mul8(s1_ff.rb.r, s1_ff.sat);
      s2_in.rs.g     = hsvrgbw_pkg::mul8(s1_ff.rb.g, s1_ff.sat);
      s2_in.rs.b     = hsvrgbw_pkg::mul8(s1_ff.rb.b, s1_ff.sat);
   end

   // Stage three: blend white in or move it to the white channel, then value.
   always_comb begin
      if (s2_ff.sat_full) begin
         mix = {s2_ff.rb, 8'd0};
      end else if (s2_ff.sat_zero) begin
         if (strip_white_ff) begin
            mix = {8'd0, 8'd0, 8'd0, hsvrgbw_pkg::LEVEL_MAX};
         end else begin
            mix = {hsvrgbw_pkg::LEVEL_MAX, hsvrgbw_pkg::LEVEL_MAX,
                   hsvrgbw_pkg::LEVEL_MAX, 8'd0};
         end
      end else if (strip_white_ff) begin
         mix = {s2_ff.rs, s2_ff.desat};
      end else begin
         mix.r = s2_ff.rs.r + s2_ff.desat;
         mix.g = s2_ff.rs.g + s2_ff.desat;
         mix.b = s2_ff.rs.b + s2_ff.desat;
         mix.w = 8'd0;
      end

      if (s2_ff.val == hsvrgbw_pkg::LEVEL_MAX) begin
         s3_in = mix;
      end else if (s2_ff.val == 8'd0) begin
         s3_in = '0;
      end else begin
         s3_in.r = hsvrgbw_pkg::mul8(mix.r, s2_ff.val);
         s3_in.g = hsvrgbw_pkg::mul8(mix.g, s2_ff.val);
         s3_in.b = hsvrgbw_pkg::mul8(mix.b, s2_ff.val);
         s3_in.w = hsvrgbw_pkg::mul8(mix.w, s2_ff.val);
      end
   end

   // Stage four: colour correction of red, green and blue; white passes through.
   always_comb begin
      s4_in.r = hsvrgbw_pkg::mul8(s3_ff.r, corr_red_ff);
      s4_in.g = hsvrgbw_pkg::mul8(s3_ff.g, corr_green_ff);
      s4_in.b = hsvrgbw_pkg::mul8(s3_ff.b, corr_blue_ff);
      s4_in.w = s3_ff.w;
   end

   // Stage five: pack the channels into the LED word.
   assign word_in = {24'd0, s4_ff.w}
                  | hsvrgbw_pkg::place(s4_ff.r, channel_order_ff[23:16], strip_white_ff)
                  | hsvrgbw_pkg::place(s4_ff.g, channel_order_ff[15:8], strip_white_ff)
                  | hsvrgbw_pkg::place(s4_ff.b, channel_order_ff[7:0], strip_white_ff);

   // Payload registers.
   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
      if (en4) s4_ff <= s4_in;
      if (en5) begin
         s5_ff   <= s4_ff;
         word_ff <= word_in;
      end
   end

   assign rsp_valid      = v5_ff;
   assign rsp_pixel_word = word_ff;
   assign rsp_red_out    = s5_ff.r;
   assign rsp_green_out  = s5_ff.g;
   assign rsp_blue_out   = s5_ff.b;
   assign rsp_white_out  = s5_ff.w;

   // An accepted beat always lands in the first stage.
   `HSVRGBW_ASSERT_NEXT(a_accept_fills, clock, reset, req_valid && !req_stall, v1_ff, "accepted beat lost at stage one")

   // A held stage keeps its beat.
   `HSVRGBW_ASSERT_NEXT(a_stage2_holds, clock, reset, v2_ff && !en3, v2_ff, "stage two dropped a held beat")

   // Zero value blanks every channel, white included.
   `HSVRGBW_ASSERT_NEXT(a_zero_value, clock, reset, v2_ff && en3 && s2_ff.val == 8'd0, s3_ff == '0, "zero value did not blank the pixel")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_PIXELS = 75;
   localparam int PHASE_COUNT = 6;
   localparam int REPORT_LIMIT = 10;

   // Index past the register list; writes there must be ignored.
   localparam logic [hsvrgbw_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   typedef struct packed {
      logic [31:0] word;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  white;
   } pixel_levels_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_hue = 8'd0;
   logic [7:0]                          req_sat_in = 8'd0;
   logic [7:0]                          req_value_in = 8'd0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [31:0]                         rsp_pixel_word;
   logic [7:0]                          rsp_red_out;
   logic [7:0]                          rsp_green_out;
   logic [7:0]                          rsp_blue_out;
   logic [7:0]                          rsp_white_out;
   logic                                csr_wr_en = 1'b0;
   logic [hsvrgbw_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [hsvrgbw_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Mirror of the configuration registers.
   logic [7:0]  cfg_corr_red = 8'd255;
   logic [7:0]  cfg_corr_green = 8'd255;
   logic [7:0]  cfg_corr_blue = 8'd255;
   logic [7:0]  cfg_sat_gain = 8'd255;
   logic [7:0]  cfg_brightness = 8'd255;
   logic        cfg_white = 1'b0;
   logic [23:0] cfg_order = 24'h081000;

   pixel_levels_type expected_pixels[$];
   pixel_levels_type head_pixel;
   pixel_levels_type got_pixel;
   int               failures = 0;
   int               cycles = 0;
   int               burst_left = 4;
   bit               valid_high = 1'b0;
   stall_style_type  stall_style = STALL_NONE;
   int               stall_left = 0;
   int               stall_tick = 0;

   hsv_rainbow_to_rgbw_pixel_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_sat_in     (req_sat_in),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_word (rsp_pixel_word),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_white_out  (rsp_white_out),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #4 clock = ~clock;

   // Abort a run that hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding", cycles,
                  expected_pixels.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Eight-bit scaling: the product keeps its high byte.
   function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
      logic [15:0] prod;
      prod = {8'd0, a} * {8'd0, b};
      return prod[15:8];
   endfunction

   // A channel whose shift reaches past bit 31 falls out of the word.
   function automatic logic [31:0] shift_into_word(input logic [7:0] level,
                                                   input logic [8:0] amount);
      if (amount >= 9'd32) begin
         return 32'd0;
      end
      return {24'd0, level} << amount[4:0];
   endfunction

   // Expected channel levels and packed word for one pixel.
   function automatic pixel_levels_type predict_pixel(input logic [7:0] hue,
                                                      input logic [7:0] sat_in,
                                                      input logic [7:0] value_in);
      logic [7:0]       sat;
      logic [7:0]       vsq;
      logic [7:0]       val;
      logic [7:0]       off8;
      logic [7:0]       third;
      logic [7:0]       inv;
      logic [7:0]       desat;
      logic [7:0]       r;
      logic [7:0]       g;
      logic [7:0]       b;
      logic [7:0]       w;
      logic [8:0]       extra;
      pixel_levels_type res;
      sat = scale8(sat_in, cfg_sat_gain);
      vsq = scale8(value_in, value_in);
      if (vsq != 8'd0 && vsq != 8'd255) begin
         vsq = vsq + 8'd1;
      end
      val = scale8(vsq, cfg_brightness);
      off8 = {hue[4:0], 3'b000};
      third = off8 / 8'd3;
      w = 8'd0;

      // Rainbow segment; every sum wraps at eight bits.
      case (hsvrgbw_pkg::seg_type'(hue[7:5]))
         hsvrgbw_pkg::SEG_RED: begin
            r = 8'd255 - third;        g = third;                 b = 8'd0;
         end
         hsvrgbw_pkg::SEG_ORANGE: begin
            r = 8'd171;                g = 8'd85 + third;         b = 8'd0;
         end
         hsvrgbw_pkg::SEG_YELLOW: begin
            r = 8'd171 - (third << 1); g = 8'd170 + third;        b = 8'd0;
         end
         hsvrgbw_pkg::SEG_GREEN: begin
            r = 8'd0;                  g = 8'd255 - third;        b = third;
         end
         hsvrgbw_pkg::SEG_AQUA: begin
            r = 8'd0;                  g = 8'd171 - (third << 1); b = 8'd85 + (third << 1);
         end
         hsvrgbw_pkg::SEG_BLUE: begin
            r = third;                 g = 8'd0;                  b = 8'd255 - third;
         end
         hsvrgbw_pkg::SEG_PURPLE: begin
            r = 8'd85 + third;         g = 8'd0;                  b = 8'd171 - third;
         end
         default: begin
            r = 8'd170 + third;        g = 8'd0;                  b = 8'd85 - third;
         end
      endcase

      // Desaturation goes either into the colors or into the white channel.
      if (sat != 8'd255) begin
         if (sat == 8'd0) begin
            if (cfg_white) begin
               r = 8'd0; g = 8'd0; b = 8'd0; w = 8'd255;
            end else begin
               r = 8'd255; g = 8'd255; b = 8'd255;
            end
         end else begin
            inv = 8'd255 - sat;
            desat = scale8(inv, inv);
            r = scale8(r, sat);
            g = scale8(g, sat);
            b = scale8(b, sat);
            if (cfg_white) begin
               w = desat;
            end else begin
               r = r + desat;
               g = g + desat;
               b = b + desat;
            end
         end
      end

      // Value scaling, then color correction on red, green and blue only.
      if (val != 8'd255) begin
         if (val == 8'd0) begin
            r = 8'd0; g = 8'd0; b = 8'd0; w = 8'd0;
         end else begin
            r = scale8(r, val);
            g = scale8(g, val);
            b = scale8(b, val);
            w = scale8(w, val);
         end
      end
      r = scale8(r, cfg_corr_red);
      g = scale8(g, cfg_corr_green);
      b = scale8(b, cfg_corr_blue);

      extra = cfg_white ? 9'd8 : 9'd0;
      res.word = {24'd0, w}
               | shift_into_word(r, {1'b0, cfg_order[23:16]} + extra)
               | shift_into_word(g, {1'b0, cfg_order[15:8]} + extra)
               | shift_into_word(b, {1'b0, cfg_order[7:0]} + extra);
      res.red = r;
      res.green = g;
      res.blue = b;
      res.white = w;
      return res;
   endfunction

   // Drop valid if it is high, then let the given number of cycles pass.
   task automatic idle_sender(input int n);
      if (valid_high) begin
         req_valid <= 1'b0;
         valid_high = 1'b0;
      end
      repeat (n) @(posedge clock);
   endtask

   // Send one pixel beat, record its expected result, and pause at burst ends.
   task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] val);
      req_hue <= hue;
      req_sat_in <= sat;
      req_value_in <= val;
      req_valid <= 1'b1;
      valid_high = 1'b1;
      do @(posedge clock); while (req_stall);
      expected_pixels.push_back(predict_pixel(hue, sat, val));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
         idle_sender($urandom_range(1, 6));
      end
   endtask

   // Hold off the sender until every expected pixel has come back.
   task automatic wait_all_results();
      idle_sender(1);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; the mirror keeps only the register's width.
   task automatic write_reg(input logic [hsvrgbw_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [23:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (hsvrgbw_pkg::csr_index_type'(idx))
         hsvrgbw_pkg::CSR_CORR_RED:      cfg_corr_red = data[7:0];
         hsvrgbw_pkg::CSR_CORR_GREEN:    cfg_corr_green = data[7:0];
         hsvrgbw_pkg::CSR_CORR_BLUE:     cfg_corr_blue = data[7:0];
         hsvrgbw_pkg::CSR_SAT_GAIN:      cfg_sat_gain = data[7:0];
         hsvrgbw_pkg::CSR_BRIGHTNESS:    cfg_brightness = data[7:0];
         hsvrgbw_pkg::CSR_STRIP_WHITE:   cfg_white = data[0];
         hsvrgbw_pkg::CSR_CHANNEL_ORDER: cfg_order = data;
         default: ;
      endcase
   endtask

   // Receiver stall: a new random style is drawn each time the stall_left count runs out.
   always @(posedge clock) begin
      stall_tick++;
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left = $urandom_range(16, 96);
      end else begin
         stall_left--;
      end
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
         default:     rsp_stall <= ((stall_tick % 5) < 2);
      endcase
   end

   // Compare every accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_pixel = {rsp_pixel_word, rsp_red_out, rsp_green_out, rsp_blue_out,
                      rsp_white_out};
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("unexpected pixel beat: word=%h r=%h g=%h b=%h w=%h",
                        got_pixel.word, got_pixel.red, got_pixel.green,
                        got_pixel.blue, got_pixel.white);
            end
         end else begin
            head_pixel = expected_pixels.pop_front();
            if (got_pixel !== head_pixel) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("pixel mismatch: expected word=%h r=%h g=%h b=%h w=%h",
                           head_pixel.word, head_pixel.red, head_pixel.green,
                           head_pixel.blue, head_pixel.white);
                  $display("                got      word=%h r=%h g=%h b=%h w=%h",
                           got_pixel.word, got_pixel.red, got_pixel.green,
                           got_pixel.blue, got_pixel.white);
               end
            end
         end
      end
   end

   // Each segment at fully saturated, full value, with edge offsets.
   task automatic test_rainbow_segments();
      send_pixel(8'h00, 8'd255, 8'd255);
      send_pixel(8'h3F, 8'd255, 8'd255);
      send_pixel(8'h45, 8'd255, 8'd255);
      send_pixel(8'h7F, 8'd255, 8'd255);
      send_pixel(8'h80, 8'd255, 8'd255);
      send_pixel(8'hBF, 8'd255, 8'd255);
      send_pixel(8'hC0, 8'd255, 8'd255);
      send_pixel(8'hFF, 8'd255, 8'd255);
   endtask

   // Zero and full saturation and value on an RGB strip.
   task automatic test_sat_value_extremes();
      send_pixel(8'h20, 8'd0, 8'd255);
      send_pixel(8'h60, 8'd255, 8'd0);
      send_pixel(8'hA0, 8'd1, 8'd1);
      send_pixel(8'h10, 8'd128, 8'd255);
      send_pixel(8'hE0, 8'd254, 8'd128);
      send_pixel(8'h00, 8'd0, 8'd0);
   endtask

   // RGBW strip: desaturation moves into the white channel.
   task automatic test_white_strip();
      wait_all_results();
      write_reg(hsvrgbw_pkg::CSR_STRIP_WHITE, 24'd1);
      send_pixel(8'h40, 8'd0, 8'd255);
      send_pixel(8'h90, 8'd100, 8'd200);
      send_pixel(8'h50, 8'd255, 8'd255);
      send_pixel(8'hF0, 8'd0, 8'd0);
      wait_all_results();
      write_reg(hsvrgbw_pkg::CSR_STRIP_WHITE, 24'd0);
   endtask

   // Shifts that push a channel partly or fully out of the word.
   task automatic test_large_shift();
      wait_all_results();
      write_reg(hsvrgbw_pkg::CSR_STRIP_WHITE, 24'd1);
      write_reg(hsvrgbw_pkg::CSR_CHANNEL_ORDER, 24'h181008);
      send_pixel(8'h30, 8'd200, 8'd240);
      wait_all_results();
      write_reg(hsvrgbw_pkg::CSR_STRIP_WHITE, 24'd0);
      write_reg(hsvrgbw_pkg::CSR_CHANNEL_ORDER, 24'hFF2008);
      send_pixel(8'h70, 8'd255, 8'd255);
      wait_all_results();
      write_reg(hsvrgbw_pkg::CSR_CHANNEL_ORDER, 24'h1F0000);
      send_pixel(8'hD5, 8'd255, 8'd255);
      wait_all_results();
      write_reg(hsvrgbw_pkg::CSR_CHANNEL_ORDER, 24'h081000);
   endtask

   // An unknown index is ignored and wide data is cut to the register width.
   task automatic test_csr_handling();
      wait_all_results();
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      write_reg(hsvrgbw_pkg::CSR_BRIGHTNESS, 24'hABCD80);
      write_reg(hsvrgbw_pkg::CSR_STRIP_WHITE, 24'hFFFFFE);
      write_reg(hsvrgbw_pkg::CSR_CORR_RED, 24'd0);
      write_reg(hsvrgbw_pkg::CSR_CORR_GREEN, 24'h5A5AFF);
      write_reg(hsvrgbw_pkg::CSR_CORR_BLUE, 24'h000040);
      write_reg(hsvrgbw_pkg::CSR_SAT_GAIN, 24'h123400);
      send_pixel(8'h1C, 8'd77, 8'd255);
      send_pixel(8'hB3, 8'd255, 8'd190);
   endtask

   // Mostly random, with extra weight on the boundary levels.
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_shift();
      case ($urandom_range(0, 3))
         0:       return 8'($urandom_range(0, 255));
         1:       return 8'($urandom_range(0, 40));
         default: return 8'($urandom_range(0, 3) * 8);
      endcase
   endfunction

   // Random pixels under several register settings, draining between them.
   task automatic test_random_pixels();
      logic [7:0]  level;
      logic [23:0] order;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_all_results();
         for (int idx = 0; idx < 5; idx++) begin
            if (phase == 0) begin
               level = 8'd255;
            end else if (phase == 1) begin
               level = 8'd0;
            end else begin
               level = pick_level();
            end
            write_reg(idx[hsvrgbw_pkg::CSR_INDEX_W-1:0],
                      {16'($urandom_range(0, 65535)), level});
         end
         write_reg(hsvrgbw_pkg::CSR_STRIP_WHITE, 24'($urandom_range(0, 24'hFFFFFF)));
         if (phase == 2) begin
            order = 24'hFFFFFF;
         end else if (phase == 3) begin
            order = 24'($urandom_range(0, 24'hFFFFFF));
         end else begin
            order = {pick_shift(), pick_shift(), pick_shift()};
         end
         write_reg(hsvrgbw_pkg::CSR_CHANNEL_ORDER, order);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_rainbow_segments();
      test_sat_value_extremes();
      test_white_strip();
      test_large_shift();
      test_csr_handling();
      test_random_pixels();
      wait_all_results();
      failures += expected_pixels.size();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
